@@ design/vmd_pkg.sv @@
// ----------------------------------------------------------------------------
// vmd_pkg
// Shared widths, codes and control types of the voxel mask DDA unit.
// ----------------------------------------------------------------------------
package vmd_pkg;

   localparam int MASK_W    = 64;
   localparam int START_W   = 18;
   localparam int DIR_W     = 16;
   localparam int FRAC_BITS = 16;
   localparam int COORD_W   = 2;
   localparam int INDEX_W   = 6;
   localparam int TESTED_W  = 4;
   localparam int NUM_AXES  = 3;

   localparam int MAX_STEPS = 11;
   localparam int CNT_W     = $clog2(MAX_STEPS + 1);

   // reciprocal 2^31 / |d| in Q16.16, formed a byte per cycle
   localparam int INV_W      = 32;
   localparam int DIST_W     = 32;
   localparam int DIV_STEP   = 8;
   localparam int DIV_ROUNDS = INV_W / DIV_STEP;
   localparam int ROUND_W    = $clog2(DIV_ROUNDS);
   localparam int REM_W      = DIR_W + 1;

   localparam int PART_W = FRAC_BITS + 1;
   localparam int PROD_W = PART_W + INV_W;

   localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
   localparam logic [COORD_W-1:0] COORD_MAX = '1;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_SIDE,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic     load;
      logic     div_go;
      logic     div_first;
      logic     mul_go;
      logic     side_go;
      logic     walk_go;
      logic     emit;
      axis_type axis;
   } vmd_cmd_type;

   typedef struct packed {
      logic walk_fin;
   } vmd_status_type;

endpackage

@@ design/vmd_if.sv @@
// ----------------------------------------------------------------------------
// vmd_if
// Ray request and traversal response channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface vmd_req_if import vmd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [MASK_W-1:0]        occupancy_mask;
   logic [START_W-1:0]       start_x;
   logic [START_W-1:0]       start_y;
   logic [START_W-1:0]       start_z;
   logic signed [DIR_W-1:0]  dir_x;
   logic signed [DIR_W-1:0]  dir_y;
   logic signed [DIR_W-1:0]  dir_z;

   modport source (
      output valid, occupancy_mask, start_x, start_y, start_z, dir_x, dir_y, dir_z,
      input  ready
   );
   modport sink (
      input  valid, occupancy_mask, start_x, start_y, start_z, dir_x, dir_y, dir_z,
      output ready
   );
endinterface

interface vmd_rsp_if import vmd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                hit;
   logic [INDEX_W-1:0]  cell_index;
   logic [TESTED_W-1:0] cells_tested;

   modport source (
      output valid, hit, cell_index, cells_tested,
      input  ready
   );
   modport sink (
      input  valid, hit, cell_index, cells_tested,
      output ready
   );
endinterface

@@ design/vmd_ctrl.sv @@
// ----------------------------------------------------------------------------
// vmd_ctrl
// Sequencer: per-axis divide, multiply and side setup, then the cell walk,
// then hand-off into the response register.
// ----------------------------------------------------------------------------
module vmd_ctrl import vmd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output vmd_cmd_type    cmd,
   input  vmd_status_type status
);

   state_type            state_ff, state_in;
   axis_type             axis_ff, axis_in;
   logic [ROUND_W-1:0]   round_ff, round_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_free;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign rsp_valid = out_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (round_ff == ROUND_W'(DIV_ROUNDS - 1)) state_in = ST_MUL;
         end
         ST_MUL:  state_in = ST_SIDE;
         ST_SIDE: begin
            state_in = (axis_ff == AXIS_Z) ? ST_WALK : ST_DIV;
         end
         ST_WALK: begin
            if (status.walk_fin) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd           = '0;
      cmd.axis      = axis_ff;
      req_ready     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DIV: begin
            cmd.div_go    = 1'b1;
            cmd.div_first = (round_ff == '0);
         end
         ST_MUL:  cmd.mul_go  = 1'b1;
         ST_SIDE: cmd.side_go = 1'b1;
         ST_WALK: cmd.walk_go = 1'b1;
         ST_DONE: cmd.emit    = out_free;
         default: ;
      endcase
   end

   // axis and divide round counters, response valid
   always_comb begin
      axis_in      = axis_ff;
      round_in     = round_ff;
      out_valid_in = out_valid_ff;
      if (state_ff == ST_IDLE) begin
         axis_in  = AXIS_X;
         round_in = '0;
      end
      if (state_ff == ST_DIV) begin
         round_in = round_ff + ROUND_W'(1);
      end
      if (state_ff == ST_SIDE) begin
         case (axis_ff)
            AXIS_X:  axis_in = AXIS_Y;
            AXIS_Y:  axis_in = AXIS_Z;
            default: axis_in = AXIS_X;
         endcase
      end
      if (rsp_ready) out_valid_in = 1'b0;
      if (cmd.emit)  out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= AXIS_X;
         round_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         round_ff     <= round_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

@@ design/vmd_dp.sv @@
// ----------------------------------------------------------------------------
// vmd_dp
// Datapath: shared reciprocal divider, side distance multiplier, per-axis
// distance registers, the one-cell-per-cycle walk and the response register.
// ----------------------------------------------------------------------------
module vmd_dp import vmd_pkg::*; (
   input  logic                     clock,
   input  vmd_cmd_type              cmd,
   output vmd_status_type           status,
   input  logic [MASK_W-1:0]        occupancy_mask,
   input  logic [START_W-1:0]       start_x,
   input  logic [START_W-1:0]       start_y,
   input  logic [START_W-1:0]       start_z,
   input  logic signed [DIR_W-1:0]  dir_x,
   input  logic signed [DIR_W-1:0]  dir_y,
   input  logic signed [DIR_W-1:0]  dir_z,
   output logic                     rsp_hit,
   output logic [INDEX_W-1:0]       rsp_cell_index,
   output logic [TESTED_W-1:0]      rsp_cells_tested
);

   logic [MASK_W-1:0]       mask_ff;
   logic [FRAC_BITS-1:0]    frac_ff  [NUM_AXES];
   logic [DIR_W-1:0]        dir_ff   [NUM_AXES];
   logic [COORD_W-1:0]      coord_ff [NUM_AXES];
   logic [INV_W-1:0]        inv_ff   [NUM_AXES];
   logic [DIST_W-1:0]       side_ff  [NUM_AXES];
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [INV_W-1:0]        quo_ff, quo_in;
   logic [PROD_W-1:0]       prod_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    hit_ff;
   logic                    out_hit_ff;
   logic [INDEX_W-1:0]      out_index_ff;
   logic [TESTED_W-1:0]     out_tested_ff;

   logic [DIR_W-1:0]        cur_dir;
   logic [DIR_W-1:0]        mag;
   logic [DIV_STEP-1:0]     qbits;
   logic [PART_W-1:0]       part;
   logic [PROD_W-PART_W:0]  side_raw;
   logic [DIST_W-1:0]       side_sat;

   logic [NUM_AXES-1:0]     live;
   logic [NUM_AXES-1:0]     neg;
   logic [INDEX_W-1:0]      cur_index;
   logic                    mask_bit;
   logic                    sel_x, sel_y, sel_z;
   logic                    none_sel;
   axis_type                pick;
   logic                    at_edge;
   logic [DIST_W:0]         dist_sum;
   logic [DIST_W-1:0]       dist_next;
   logic [CNT_W-1:0]        cnt_next;
   logic                    walk_fin;

   assign cur_dir = dir_ff[cmd.axis];
   assign mag     = cur_dir[DIR_W-1] ? DIR_W'(-cur_dir) : cur_dir;

   // eight restoring divide steps per cycle on the 2^31 dividend
   always_comb begin
      logic [REM_W-1:0] r;
      r = cmd.div_first ? '0 : rem_ff;
      for (int k = 0; k < DIV_STEP; k++) begin
         r = {r[REM_W-2:0], (cmd.div_first && (k == 0))};
         if (r >= {1'b0, mag}) begin
            r                   = r - {1'b0, mag};
            qbits[DIV_STEP-1-k] = 1'b1;
         end else begin
            qbits[DIV_STEP-1-k] = 1'b0;
         end
      end
      rem_in = r;
      quo_in = {quo_ff[INV_W-DIV_STEP-1:0], qbits};
   end

   // distance from start to the first boundary along the direction sign
   always_comb begin
      if (cur_dir[DIR_W-1]) begin
         part = {1'b0, frac_ff[cmd.axis]};
      end else begin
         part = (PART_W'(1) << FRAC_BITS) - {1'b0, frac_ff[cmd.axis]};
      end
   end

   assign side_raw = prod_ff[PROD_W-1:FRAC_BITS];
   assign side_sat = side_raw[PROD_W-PART_W] ? DIST_MAX : side_raw[DIST_W-1:0];

   // walk: test, pick smallest side distance, advance one cell
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         live[a] = (dir_ff[a] != '0);
         neg[a]  = dir_ff[a][DIR_W-1];
      end
      cur_index = {coord_ff[AXIS_Y], coord_ff[AXIS_Z], coord_ff[AXIS_X]};
      mask_bit  = mask_ff[cur_index];

      sel_x = live[AXIS_X]
              && (!live[AXIS_Y] || side_ff[AXIS_X] < side_ff[AXIS_Y])
              && (!live[AXIS_Z] || side_ff[AXIS_X] < side_ff[AXIS_Z]);
      sel_y = !sel_x && live[AXIS_Y]
              && (!live[AXIS_Z] || side_ff[AXIS_Y] < side_ff[AXIS_Z]);
      sel_z = !sel_x && !sel_y && live[AXIS_Z];
      none_sel = !sel_x && !sel_y && !sel_z;

      pick = sel_x ? AXIS_X : (sel_y ? AXIS_Y : AXIS_Z);
      at_edge = neg[pick] ? (coord_ff[pick] == '0) : (coord_ff[pick] == COORD_MAX);

      dist_sum  = {1'b0, side_ff[pick]} + {1'b0, inv_ff[pick]};
      dist_next = dist_sum[DIST_W] ? DIST_MAX : dist_sum[DIST_W-1:0];

      cnt_next = cnt_ff + CNT_W'(1);
      walk_fin = mask_bit || none_sel || at_edge || (cnt_next == CNT_W'(MAX_STEPS));
   end

   assign status.walk_fin = walk_fin;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mask_ff          <= occupancy_mask;
         frac_ff[AXIS_X]  <= start_x[FRAC_BITS-1:0];
         frac_ff[AXIS_Y]  <= start_y[FRAC_BITS-1:0];
         frac_ff[AXIS_Z]  <= start_z[FRAC_BITS-1:0];
         coord_ff[AXIS_X] <= start_x[FRAC_BITS+COORD_W-1:FRAC_BITS];
         coord_ff[AXIS_Y] <= start_y[FRAC_BITS+COORD_W-1:FRAC_BITS];
         coord_ff[AXIS_Z] <= start_z[FRAC_BITS+COORD_W-1:FRAC_BITS];
         dir_ff[AXIS_X]   <= dir_x;
         dir_ff[AXIS_Y]   <= dir_y;
         dir_ff[AXIS_Z]   <= dir_z;
         cnt_ff           <= '0;
      end
      if (cmd.div_go) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (cmd.mul_go) begin
         prod_ff <= PROD_W'(part) * PROD_W'(quo_ff);
      end
      if (cmd.side_go) begin
         // zero component: never advances
         if (cur_dir == '0) begin
            inv_ff[cmd.axis]  <= '0;
            side_ff[cmd.axis] <= DIST_MAX;
         end else begin
            inv_ff[cmd.axis]  <= quo_ff;
            side_ff[cmd.axis] <= side_sat;
         end
      end
      if (cmd.walk_go) begin
         cnt_ff <= cnt_next;
         hit_ff <= mask_bit;
         if (!walk_fin) begin
            side_ff[pick]  <= dist_next;
            coord_ff[pick] <= neg[pick] ? coord_ff[pick] - COORD_W'(1)
                                        : coord_ff[pick] + COORD_W'(1);
         end
      end
      if (cmd.emit) begin
         out_hit_ff    <= hit_ff;
         out_index_ff  <= hit_ff ? cur_index : '0;
         out_tested_ff <= TESTED_W'(cnt_ff);
      end
   end

   assign rsp_hit          = out_hit_ff;
   assign rsp_cell_index   = out_index_ff;
   assign rsp_cells_tested = out_tested_ff;

endmodule

@@ design/voxel_mask_dda_4x4x4_unit.sv @@
// ----------------------------------------------------------------------------
// voxel_mask_dda_4x4x4_unit
// First occupied cell along a ray through a 4x4x4 occupancy block.
// From accept to response valid: per-axis setup (divide rounds of 8 quotient
// bits each, a multiply, a store), then the cell walk, then hand-off.
// One ray in flight at a time; the next ray can be taken in the cycle after
// hand-off, and a ray takes longer while the previous response still waits
// in the output register.
// Reset clears the sequencer and response valid; no clearing pass.
// ----------------------------------------------------------------------------
module voxel_mask_dda_4x4x4_unit import vmd_pkg::*; (
   input logic      clock,
   input logic      reset,
   vmd_req_if.sink  req,
   vmd_rsp_if.source rsp
);

   vmd_cmd_type    cmd;
   vmd_status_type status;
   logic           rsp_valid;

   vmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .status    (status)
   );

   vmd_dp u_dp (
      .clock            (clock),
      .cmd              (cmd),
      .status           (status),
      .occupancy_mask   (req.occupancy_mask),
      .start_x          (req.start_x),
      .start_y          (req.start_y),
      .start_z          (req.start_z),
      .dir_x            (req.dir_x),
      .dir_y            (req.dir_y),
      .dir_z            (req.dir_z),
      .rsp_hit          (rsp.hit),
      .rsp_cell_index   (rsp.cell_index),
      .rsp_cells_tested (rsp.cells_tested)
   );

   assign rsp.valid = rsp_valid;

endmodule

@@ design/vmd_checker.sv @@
// ----------------------------------------------------------------------------
// vmd_checker
// Port-level checks on the response channel of the voxel mask DDA unit.
// ----------------------------------------------------------------------------
module vmd_checker import vmd_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_hit,
   input logic [INDEX_W-1:0]  rsp_cell_index,
   input logic [TESTED_W-1:0] rsp_cells_tested
);

   // hold a stalled word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_hit) && $stable(rsp_cell_index) && $stable(rsp_cells_tested))
      else $error("stalled response changed");

   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_cell_index == '0)
      else $error("miss with nonzero cell index");

   a_tested_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cells_tested != '0 && rsp_cells_tested <= TESTED_W'(MAX_STEPS))
      else $error("cells tested out of range");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind voxel_mask_dda_4x4x4_unit vmd_checker u_vmd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_hit          (rsp.hit),
   .rsp_cell_index   (rsp.cell_index),
   .rsp_cells_tested (rsp.cells_tested)
);
